>>> src/iaia_pkg.sv
// Package: shared constants and types for the IMU accel interpolation block.
package iaia_pkg;

    localparam int BufferDepth = 16;
    localparam logic [15:0] SlopReset = 16'd32768;

    typedef enum logic [3:0] {
        t_IDLE,
        t_LOAD,
        t_RDWAIT,
        t_CHECK,
        t_DIV,
        t_MUL,
        t_SUM,
        t_OUT
    } t_state;

    function automatic logic [15:0] sat16(input logic signed [18:0] v);
        logic [15:0] r;
        if (v > 19'sd32767) begin
            r = 16'h7fff;
        end else if (v < -19'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

>>> src/imu_accel_interpolate_align.sv
// Top level: gyro buffering and bit-serial accel interpolation with axis rotation.
//
//  channel  | dir | tdata (low bit first)                              | tuser
//  s_axis   | in  | stamp_us[31:0], right, down, forward (16 each)      | cmd
//  m_axis   | out | stamp, gyro fwd/left/up, accel fwd/left/up          | rejected; tlast = last
//  cfg      | in  | i_cfg_wdata = slop_q16                              | -
//
// A gyro word, and an accel word that finds the buffer empty, leave the block idle.
// Otherwise the accel word walks the buffer entry by entry (read, range check,
// restoring divide, three multiplies, output load, advance); a rejected entry
// cuts the divide and the multiplies short.
// Reset is synchronous; the buffer has no reset. An unread output word holds
// the walk before the next output load; input is taken only while idle.
module imu_accel_interpolate_align
    import iaia_pkg::*;
#(
    parameter int BUFFER_DEPTH = BufferDepth
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [79:0]  s_axis_tdata,  // stamp_us, axis_right, axis_down, axis_forward
    input  logic         s_axis_tuser,  // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // out_stamp_us, gyro_fwd/left/up, accel_fwd/left/up
    output logic         m_axis_tuser,  // rejected
    output logic         m_axis_tlast   // last
);
    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic [31:0] r_gs_mem [BUFFER_DEPTH];
    logic [47:0] r_gv_mem [BUFFER_DEPTH];
    logic [31:0] r_gs_rd;
    logic [47:0] r_gv_rd;

    t_state r_state, n_state;
    logic [15:0] r_slop;
    logic [CW-1:0] r_count, r_idx;
    logic [31:0] r_pstamp, r_nstamp;
    logic [47:0] r_pval, r_nval;
    logic r_pvalid;
    logic signed [32:0] r_d;
    logic [47:0] r_quo, r_num;
    logic [32:0] r_rem;
    logic r_neg;
    logic [5:0] r_bit;
    logic [1:0] r_k;
    logic signed [19:0] r_acc [3];
    logic r_rej;
    logic [127:0] r_odata;
    logic r_ovalid, r_olast, r_orej;

    logic s_acc, s_do_gyro, s_do_accel;
    assign s_axis_tready = (r_state == t_IDLE);
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign s_do_gyro = s_acc && !s_axis_tuser && r_pvalid && (r_count < CW'(BUFFER_DEPTH));
    assign s_do_accel = s_acc && s_axis_tuser;

    // Buffer memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (s_do_gyro) begin
            r_gs_mem[r_count[AW-1:0]] <= s_axis_tdata[31:0];
            r_gv_mem[r_count[AW-1:0]] <= s_axis_tdata[79:32];
        end
        r_gs_rd <= r_gs_mem[r_idx[AW-1:0]];
        r_gv_rd <= r_gv_mem[r_idx[AW-1:0]];
    end

    // Interpolation arithmetic on signals.
    logic signed [32:0] s_n;
    logic signed [49:0] s_scaled, s_lo, s_hi;
    logic [32:0] s_rem_sh, s_dabs;
    logic s_ge;
    logic signed [16:0] s_a1, s_a2;
    logic signed [17:0] s_diff;
    logic signed [36:0] s_prod;
    logic signed [19:0] s_term;
    logic signed [47:0] s_fq;
    logic signed [18:0] s_f;

    always_comb begin
        s_n = 33'(signed'(r_gs_rd - r_pstamp));
        s_scaled = 50'(s_n) <<< 16;
        s_lo = -(50'(signed'({1'b0, r_slop})) * 50'(r_d));
        s_hi = 50'(signed'({18'd1, r_slop})) * 50'(r_d);
        s_dabs = r_d[32:0];
        s_rem_sh = {r_rem[31:0], r_num[47]};
        s_ge = (s_rem_sh >= s_dabs);
        s_fq = r_neg ? (-signed'(r_quo) - 48'(r_rem != 33'd0 ? 1 : 0)) : signed'(r_quo);
        s_f = 19'(s_fq);
        unique case (r_k)
            2'd0: begin
                s_a1 = 17'(signed'(r_pval[15:0]));
                s_a2 = 17'(signed'(r_nval[15:0]));
            end
            2'd1: begin
                s_a1 = 17'(signed'(r_pval[31:16]));
                s_a2 = 17'(signed'(r_nval[31:16]));
            end
            default: begin
                s_a1 = 17'(signed'(r_pval[47:32]));
                s_a2 = 17'(signed'(r_nval[47:32]));
            end
        endcase
        s_diff = 18'(s_a2) - 18'(s_a1);
        s_prod = 37'(s_f) * 37'(s_diff) + 37'sd32768;
        s_term = 20'(s_prod >>> 16) + 20'(s_a1);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            t_IDLE:   if (s_do_accel) n_state = (r_count == '0) ? t_IDLE : t_LOAD;
            t_LOAD:   n_state = t_RDWAIT;
            t_RDWAIT: n_state = t_CHECK;
            t_CHECK:  n_state = t_DIV;
            t_DIV:    if (r_rej || r_bit == 6'd0) n_state = t_MUL;
            t_MUL:    if (r_rej || r_k == 2'd2) n_state = t_SUM;
            t_SUM:    if (!r_ovalid) n_state = t_OUT;
            t_OUT:    n_state = (r_idx == r_count) ? t_IDLE : t_LOAD;
            default:  n_state = t_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_IDLE;
            r_slop <= SlopReset;
            r_count <= '0;
            r_idx <= '0;
            r_pvalid <= 1'b0;
            r_pstamp <= '0;
            r_pval <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_slop <= i_cfg_wdata;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            if (s_do_gyro) r_count <= r_count + 1'b1;
            if (s_do_accel) begin
                r_nstamp <= s_axis_tdata[31:0];
                r_nval <= s_axis_tdata[79:32];
                r_d <= 33'(signed'(s_axis_tdata[31:0] - r_pstamp));
                r_idx <= '0;
                if (r_count == '0) begin
                    r_pstamp <= s_axis_tdata[31:0];
                    r_pval <= s_axis_tdata[79:32];
                    r_pvalid <= 1'b1;
                end
            end
            unique case (r_state)
                t_CHECK: begin
                    r_rej <= (r_d <= 33'sd0) || (s_scaled < s_lo) || (s_scaled > s_hi);
                    r_neg <= s_n[32];
                    r_num <= s_n[32] ? 48'(-s_scaled) : 48'(s_scaled);
                    r_rem <= '0;
                    r_quo <= '0;
                    r_bit <= 6'd47;
                end
                t_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    r_rem <= s_ge ? s_rem_sh - s_dabs : s_rem_sh;
                    r_quo <= {r_quo[46:0], s_ge};
                    r_num <= {r_num[46:0], 1'b0};
                    r_bit <= r_bit - 1'b1;
                    r_k <= 2'd0;
                end
                t_MUL: begin
                    r_acc[r_k] <= s_term;
                    r_k <= r_k + 1'b1;
                end
                t_SUM: begin
                    // hold until the output register is free
                    if (!r_ovalid) begin
                        r_odata[31:0] <= r_gs_rd;
                        r_odata[47:32] <= r_gv_rd[47:32];
                        r_odata[63:48] <= sat16(-19'(signed'(r_gv_rd[15:0])));
                        r_odata[79:64] <= sat16(-19'(signed'(r_gv_rd[31:16])));
                        r_odata[95:80] <= r_rej ? 16'd0 : sat16(19'(r_acc[2]));
                        r_odata[111:96] <= r_rej ? 16'd0 : sat16(-19'(r_acc[0]));
                        r_odata[127:112] <= r_rej ? 16'd0 : sat16(-19'(r_acc[1]));
                        r_orej <= r_rej;
                        r_olast <= (r_idx + 1'b1 == r_count);
                        r_idx <= r_idx + 1'b1;
                        r_ovalid <= 1'b1;
                    end
                end
                t_OUT: begin
                    if (r_idx == r_count) begin
                        r_count <= '0;
                        r_pstamp <= r_nstamp;
                        r_pval <= r_nval;
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = r_odata;
    assign m_axis_tuser = r_orej;
    assign m_axis_tlast = r_olast;

endmodule
